// ===== src/atc_pkg.sv =====
// Shared types, codes and constants of the accelerometer tilt calibration unit.
package atc_pkg;

  // operation codes
  localparam logic [1:0] OPC_START   = 2'd0;
  localparam logic [1:0] OPC_SAMPLE  = 2'd1;
  localparam logic [1:0] OPC_FINISH  = 2'd2;
  localparam logic [1:0] OPC_MEASURE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_UNCAL    = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // register reset values
  localparam logic [14:0] GAIN_LOW_RESET  = 15'd200;
  localparam logic [14:0] GAIN_HIGH_RESET = 15'd320;
  localparam logic [14:0] GAIN_RESET      = 15'd255;

  // sequencing
  localparam int STEP_W     = 5;
  localparam int PROD_STEPS = 7;
  localparam int SQ_STEPS   = 3;
  localparam int ROOT_STEPS = 31;

  // angles in centidegrees, Q16
  localparam logic signed [32:0] HALF_Q16    = 33'sd1179648000;
  localparam logic signed [32:0] QUARTER_Q16 = 33'sd589824000;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_PROD,
    DP_MAX,
    DP_NORM,
    DP_SQ,
    DP_ROOT,
    DP_CINIT,
    DP_CITER,
    DP_CDONE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic                pitch_sel;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic measure_req;
    logic norm_done;
    logic out_free;
  } dp_stat_t;

  // arctangent of 2^-i in centidegrees Q16, rounded to nearest
  function automatic logic [28:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [28:0] r;
    case (i)
      5'd0:  r = 29'd294912000;
      5'd1:  r = 29'd174096719;
      5'd2:  r = 29'd91987925;
      5'd3:  r = 29'd46694507;
      5'd4:  r = 29'd23437865;
      5'd5:  r = 29'd11730358;
      5'd6:  r = 29'd5866610;
      5'd7:  r = 29'd2933484;
      5'd8:  r = 29'd1466764;
      5'd9:  r = 29'd733385;
      5'd10: r = 29'd366693;
      5'd11: r = 29'd183346;
      5'd12: r = 29'd91673;
      5'd13: r = 29'd45837;
      5'd14: r = 29'd22918;
      5'd15: r = 29'd11459;
      5'd16: r = 29'd5730;
      5'd17: r = 29'd2865;
      5'd18: r = 29'd1432;
      5'd19: r = 29'd716;
      5'd20: r = 29'd358;
      5'd21: r = 29'd179;
      5'd22: r = 29'd90;
      5'd23: r = 29'd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/atc_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface atc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, operation, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, operation, sample_x, sample_y, sample_z, output ready);
endinterface

interface atc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] roll_centideg;
  logic [7:0]         tilt_sequence;
  logic signed [15:0] lowest_x;
  logic signed [15:0] highest_x;
  logic signed [15:0] lowest_y;
  logic signed [15:0] highest_y;
  logic signed [15:0] lowest_z;
  logic signed [15:0] highest_z;

  modport source (output valid, status, pitch_centideg, roll_centideg, tilt_sequence,
                  lowest_x, highest_x, lowest_y, highest_y, lowest_z, highest_z,
                  input ready);
  modport sink   (input valid, status, pitch_centideg, roll_centideg, tilt_sequence,
                  lowest_x, highest_x, lowest_y, highest_y, lowest_z, highest_z,
                  output ready);
endinterface

// ===== src/accel_tilt_calibration_unit.sv =====
// Top level: gain limit registers, controller and datapath of the tilt calibration unit.
//
//   channel | direction | transfer when          | payload
//   in_ch   | in        | valid && ready         | operation, sample_x/y/z
//   out_ch  | out       | valid && ready         | status, pitch, roll, sequence, trackers
//   cfg     | in        | psel&penable&pwrite    | gain_low_limit @0, gain_high_limit @4
//
// Start, sample, finish and refused measures go straight from IDLE to EMIT.
// A measure runs PROD, MAX, NORM (0..28 normalising shifts), SQ, ROOT and CORDIC;
// the 31-step square root and the two CORDIC passes share one sequenced datapath.
// One item is in work at a time; the next is taken once the result sits in the
// output register, which holds it until out_ch.ready.
// Sync active-low reset clears control and trackers; limits return to 200 and 320.
module accel_tilt_calibration_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  atc_in_if.sink      in_ch,
  atc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0]       gain_low_r;
  logic [14:0]       gain_high_r;
  atc_pkg::dp_cmd_t  cmd;
  atc_pkg::dp_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_low_r  <= atc_pkg::GAIN_LOW_RESET;
      gain_high_r <= atc_pkg::GAIN_HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) gain_high_r <= pwdata[14:0];
      else          gain_low_r  <= pwdata[14:0];
    end
  end

  assign prdata = paddr[2] ? {17'd0, gain_high_r} : {17'd0, gain_low_r};

  atc_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_ch.operation),
    .in_sample_x  (in_ch.sample_x),
    .in_sample_y  (in_ch.sample_y),
    .in_sample_z  (in_ch.sample_z),
    .gain_low     (gain_low_r),
    .gain_high    (gain_high_r),
    .out_ch       (out_ch)
  );

endmodule

// ===== src/atc_ctrl.sv =====
// Controller state machine sequencing the tilt datapath.
module atc_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  atc_pkg::dp_stat_t stat,
  output atc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PROD  = 10'b0000000010,
    S_MAX   = 10'b0000000100,
    S_NORM  = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_ROOT  = 10'b0000100000,
    S_CINIT = 10'b0001000000,
    S_CITER = 10'b0010000000,
    S_CDONE = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  localparam logic [atc_pkg::STEP_W-1:0] PROD_LAST = atc_pkg::STEP_W'(atc_pkg::PROD_STEPS - 1);
  localparam logic [atc_pkg::STEP_W-1:0] SQ_LAST   = atc_pkg::STEP_W'(atc_pkg::SQ_STEPS - 1);
  localparam logic [atc_pkg::STEP_W-1:0] ROOT_LAST = atc_pkg::STEP_W'(atc_pkg::ROOT_STEPS - 1);
  localparam logic [atc_pkg::STEP_W-1:0] CORD_LAST = atc_pkg::STEP_W'(CORDIC_STEPS - 1);

  state_t                      state_r, state_nxt;
  logic [atc_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        pitch_r, pitch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pitch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pitch_nxt     = pitch_r;
    in_ready      = 1'b0;
    cmd.op        = atc_pkg::DP_NONE;
    cmd.step      = step_r;
    cmd.pitch_sel = pitch_r;
    case (state_r)
      S_IDLE: begin
        // no transfer while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.op    = atc_pkg::DP_ACCEPT;
          step_nxt  = '0;
          pitch_nxt = 1'b0;
          state_nxt = stat.measure_req ? S_PROD : S_EMIT;
        end
      end
      S_PROD: begin
        cmd.op = atc_pkg::DP_PROD;
        if (step_r == PROD_LAST) begin
          step_nxt  = '0;
          state_nxt = S_MAX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MAX: begin
        cmd.op    = atc_pkg::DP_MAX;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          step_nxt  = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.op = atc_pkg::DP_NORM;
        end
      end
      S_SQ: begin
        cmd.op = atc_pkg::DP_SQ;
        if (step_r == SQ_LAST) begin
          step_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.op = atc_pkg::DP_ROOT;
        if (step_r == ROOT_LAST) begin
          step_nxt  = '0;
          state_nxt = S_CINIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.op    = atc_pkg::DP_CINIT;
        step_nxt  = '0;
        state_nxt = S_CITER;
      end
      S_CITER: begin
        cmd.op = atc_pkg::DP_CITER;
        if (step_r == CORD_LAST) begin
          step_nxt  = '0;
          state_nxt = S_CDONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CDONE: begin
        cmd.op = atc_pkg::DP_CDONE;
        if (pitch_r) begin
          state_nxt = S_EMIT;
        end else begin
          pitch_nxt = 1'b1;
          state_nxt = S_CINIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = atc_pkg::DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/atc_dp.sv =====
// Datapath: calibration trackers, cross-product scaling, square root, CORDIC and result register.
module atc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  atc_pkg::dp_cmd_t   cmd,
  output atc_pkg::dp_stat_t  stat,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic signed [15:0] in_sample_z,
  input  logic [14:0]        gain_low,
  input  logic [14:0]        gain_high,
  atc_out_if.source          out_ch
);

  localparam logic [46:0] M_HI = 47'd1 << 29;
  localparam logic [46:0] M_LO = 47'd1 << 28;

  // calibration state
  logic signed [15:0] min_r [3];
  logic signed [15:0] max_r [3];
  logic signed [15:0] off_r [3];
  logic [14:0]        gain_r [3];
  logic               calibrating_r;
  logic               calibrated_r;
  logic [7:0]         seq_cnt_r;

  // working registers
  logic signed [15:0] smp_r [3];
  logic signed [63:0] prod_r;
  logic signed [47:0] v_r [3];
  logic [46:0]        m_r;
  logic [61:0]        n_r, root_r, bit_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic               cfix_r;
  logic [1:0]         res_status_r;
  logic [7:0]         res_seq_r;
  logic signed [14:0] res_pitch_r;
  logic signed [15:0] res_roll_r;

  // output register
  logic               out_valid_r;
  logic [1:0]         o_status_r;
  logic signed [14:0] o_pitch_r;
  logic signed [15:0] o_roll_r;
  logic [7:0]         o_seq_r;
  logic signed [15:0] o_min_r [3];
  logic signed [15:0] o_max_r [3];

  logic signed [15:0] in_smp [3];
  logic signed [15:0] fin_off [3];
  logic [14:0]        fin_gain [3];
  logic               fin_ok;
  logic signed [16:0] d [3];
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [46:0]        mag_v [3];
  logic [46:0]        mag_max;
  logic [61:0]        trial;
  logic signed [33:0] ci_x, ci_y, ci_sx, ci_sy;
  logic signed [32:0] ci_z;
  logic               ci_fix;
  logic signed [33:0] cx_sh, cy_sh;
  logic signed [32:0] at;
  logic signed [32:0] q_neg, cdeg, lim;

  assign in_smp[0] = in_sample_x;
  assign in_smp[1] = in_sample_y;
  assign in_smp[2] = in_sample_z;

  // finish: midpoint and half range, truncated toward zero
  always_comb begin
    logic signed [16:0] sum;
    logic signed [16:0] dif;
    logic signed [16:0] hs;
    logic signed [16:0] hd;
    fin_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      sum = {max_r[k][15], max_r[k]} + {min_r[k][15], min_r[k]};
      dif = {max_r[k][15], max_r[k]} - {min_r[k][15], min_r[k]};
      hs  = (sum + {16'd0, sum[16]}) >>> 1;
      hd  = (dif + {16'd0, dif[16]}) >>> 1;
      fin_off[k]  = hs[15:0];
      fin_gain[k] = hd[14:0];
      if (hd < $signed({2'b00, gain_low}) || hd > $signed({2'b00, gain_high})) begin
        fin_ok = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = {smp_r[k][15], smp_r[k]} - {off_r[k][15], off_r[k]};
    end
  end

  // shared multiplier: cross-products, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == atc_pkg::DP_SQ) begin
      mul_a = (cmd.step == '0) ? v_r[1][31:0] : v_r[2][31:0];
      mul_b = mul_a;
    end else begin
      case (cmd.step)
        5'd0: begin mul_a = {{15{d[0][16]}}, d[0]}; mul_b = {17'd0, gain_r[1]}; end
        5'd1: begin mul_a = prod_r[31:0];           mul_b = {17'd0, gain_r[2]}; end
        5'd2: begin mul_a = {{15{d[1][16]}}, d[1]}; mul_b = {17'd0, gain_r[0]}; end
        5'd3: begin mul_a = prod_r[31:0];           mul_b = {17'd0, gain_r[2]}; end
        5'd4: begin mul_a = {{15{d[2][16]}}, d[2]}; mul_b = {17'd0, gain_r[0]}; end
        5'd5: begin mul_a = prod_r[31:0];           mul_b = {17'd0, gain_r[1]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic signed [47:0] neg;
    for (int k = 0; k < 3; k++) begin
      neg      = -v_r[k];
      mag_v[k] = v_r[k][47] ? neg[46:0] : v_r[k][46:0];
    end
    mag_max = mag_v[0];
    if (mag_v[1] > mag_max) mag_max = mag_v[1];
    if (mag_v[2] > mag_max) mag_max = mag_v[2];
  end

  assign trial = root_r + bit_r;

  // CORDIC start: quadrant fold and exact axes
  always_comb begin
    if (cmd.pitch_sel) begin
      ci_x = root_r[33:0];
      ci_y = -v_r[0][33:0];
    end else begin
      ci_x = v_r[2][33:0];
      ci_y = v_r[1][33:0];
    end
    ci_sx  = ci_x;
    ci_sy  = ci_y;
    ci_z   = '0;
    ci_fix = 1'b0;
    if (ci_y == '0) begin
      ci_fix = 1'b1;
      ci_z   = ci_x[33] ? atc_pkg::HALF_Q16 : '0;
    end else if (ci_x == '0) begin
      ci_fix = 1'b1;
      ci_z   = ci_y[33] ? -atc_pkg::QUARTER_Q16 : atc_pkg::QUARTER_Q16;
    end else if (ci_x[33]) begin
      ci_z  = ci_y[33] ? -atc_pkg::HALF_Q16 : atc_pkg::HALF_Q16;
      ci_sx = -ci_x;
      ci_sy = -ci_y;
    end
  end

  assign cx_sh = cx_r >>> cmd.step;
  assign cy_sh = cy_r >>> cmd.step;
  assign at    = {4'd0, atc_pkg::atan_q16(cmd.step)};

  // truncate toward zero to centidegrees, then clamp
  always_comb begin
    q_neg = -cz_r;
    cdeg  = cz_r[32] ? -(q_neg >> 16) : (cz_r >>> 16);
    lim   = cmd.pitch_sel ? 33'sd9000 : 33'sd18000;
    if (cdeg > lim) cdeg = lim;
    if (cdeg < -lim) cdeg = -lim;
  end

  assign stat.measure_req = (in_operation == atc_pkg::OPC_MEASURE) && calibrated_r;
  assign stat.norm_done   = (m_r == '0) || (m_r < M_HI && m_r >= M_LO);
  assign stat.out_free    = !out_valid_r || out_ch.ready;

  // calibration state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        min_r[k]  <= '0;
        max_r[k]  <= '0;
        off_r[k]  <= '0;
        gain_r[k] <= atc_pkg::GAIN_RESET;
      end
      calibrating_r <= 1'b0;
      calibrated_r  <= 1'b0;
      seq_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.op == atc_pkg::DP_ACCEPT) begin
        case (in_operation)
          atc_pkg::OPC_START: begin
            for (int k = 0; k < 3; k++) begin
              min_r[k] <= 16'sh7FFF;
              max_r[k] <= 16'sh8000;
            end
            calibrating_r <= 1'b1;
          end
          atc_pkg::OPC_SAMPLE: begin
            if (calibrating_r) begin
              for (int k = 0; k < 3; k++) begin
                if (in_smp[k] < min_r[k]) min_r[k] <= in_smp[k];
                if (in_smp[k] > max_r[k]) max_r[k] <= in_smp[k];
              end
            end
          end
          atc_pkg::OPC_FINISH: begin
            calibrating_r <= 1'b0;
            if (fin_ok) begin
              for (int k = 0; k < 3; k++) begin
                off_r[k]  <= fin_off[k];
                gain_r[k] <= fin_gain[k];
              end
              calibrated_r <= 1'b1;
            end
          end
          default: begin
            if (calibrated_r) seq_cnt_r <= seq_cnt_r + 1'b1;
          end
        endcase
      end
      if (cmd.op == atc_pkg::DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      atc_pkg::DP_ACCEPT: begin
        for (int k = 0; k < 3; k++) smp_r[k] <= in_smp[k];
        res_pitch_r <= '0;
        res_roll_r  <= '0;
        res_seq_r   <= '0;
        case (in_operation)
          atc_pkg::OPC_START:  res_status_r <= atc_pkg::ST_OK;
          atc_pkg::OPC_SAMPLE: res_status_r <= calibrating_r ? atc_pkg::ST_OK
                                                             : atc_pkg::ST_IGNORED;
          atc_pkg::OPC_FINISH: res_status_r <= fin_ok ? atc_pkg::ST_OK
                                                      : atc_pkg::ST_REJECTED;
          default: begin
            res_status_r <= calibrated_r ? atc_pkg::ST_OK : atc_pkg::ST_UNCAL;
            if (calibrated_r) res_seq_r <= seq_cnt_r;
          end
        endcase
      end
      atc_pkg::DP_PROD: begin
        prod_r <= mul_p;
        case (cmd.step)
          5'd2:    v_r[0] <= prod_r[47:0];
          5'd4:    v_r[1] <= prod_r[47:0];
          5'd6:    v_r[2] <= prod_r[47:0];
          default: ;
        endcase
      end
      atc_pkg::DP_MAX: m_r <= mag_max;
      atc_pkg::DP_NORM: begin
        // right shifts round toward minus infinity
        if (m_r >= M_HI) begin
          m_r <= m_r >> 1;
          for (int k = 0; k < 3; k++) v_r[k] <= v_r[k] >>> 1;
        end else begin
          m_r <= m_r << 1;
          for (int k = 0; k < 3; k++) v_r[k] <= v_r[k] <<< 1;
        end
      end
      atc_pkg::DP_SQ: begin
        prod_r <= mul_p;
        if (cmd.step == 5'd1) begin
          n_r <= prod_r[61:0];
        end else if (cmd.step == 5'd2) begin
          n_r    <= n_r + prod_r[61:0];
          root_r <= '0;
          bit_r  <= 62'd1 << 60;
        end
      end
      atc_pkg::DP_ROOT: begin
        if (n_r >= trial) begin
          n_r    <= n_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      atc_pkg::DP_CINIT: begin
        cx_r   <= ci_sx;
        cy_r   <= ci_sy;
        cz_r   <= ci_z;
        cfix_r <= ci_fix;
      end
      atc_pkg::DP_CITER: begin
        if (!cfix_r) begin
          if (!cy_r[33]) begin
            cx_r <= cx_r + cy_sh;
            cy_r <= cy_r - cx_sh;
            cz_r <= cz_r + at;
          end else begin
            cx_r <= cx_r - cy_sh;
            cy_r <= cy_r + cx_sh;
            cz_r <= cz_r - at;
          end
        end
      end
      atc_pkg::DP_CDONE: begin
        if (cmd.pitch_sel) res_pitch_r <= cdeg[14:0];
        else               res_roll_r  <= cdeg[15:0];
      end
      atc_pkg::DP_EMIT: begin
        o_status_r <= res_status_r;
        o_pitch_r  <= res_pitch_r;
        o_roll_r   <= res_roll_r;
        o_seq_r    <= res_seq_r;
        for (int k = 0; k < 3; k++) begin
          o_min_r[k] <= min_r[k];
          o_max_r[k] <= max_r[k];
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.pitch_centideg = o_pitch_r;
  assign out_ch.roll_centideg  = o_roll_r;
  assign out_ch.tilt_sequence  = o_seq_r;
  assign out_ch.lowest_x       = o_min_r[0];
  assign out_ch.highest_x      = o_max_r[0];
  assign out_ch.lowest_y       = o_min_r[1];
  assign out_ch.highest_y      = o_max_r[1];
  assign out_ch.lowest_z       = o_min_r[2];
  assign out_ch.highest_z      = o_max_r[2];

endmodule
